@@ rtl/core/sem_pkg.sv @@
package sem_pkg;

	// Field widths of the input, result and configuration items
	localparam int PIXEL_W        = 8;
	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_INDEX_W    = 1;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	// Reset values of the frame bounds
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	// Item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic               kind;
		logic [PIXEL_W-1:0] pixel;
	} pix_item_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] edge_res;
		logic               last_of_frame;
	} res_item_t;

	typedef struct packed {
		logic [FIFO_LVL_W-1:0] level;
		logic                  full;
	} fifo_stat_t;

endpackage

@@ rtl/core/sem_stream_if.sv @@
interface sem_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/sem_result_fifo.sv @@
module sem_result_fifo import sem_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  res_item_t           push_data,
	output fifo_stat_t          stat,
	sem_stream_if.source        edges
);

	res_item_t              ent_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_LVL_W-1:0]  level_q;
	logic                   pop;

	assign pop         = edges.valid && edges.ready;
	assign edges.valid = level_q != '0;
	assign edges.data  = ent_q[rd_ptr_q];
	assign stat.level  = level_q;
	assign stat.full   = level_q == FIFO_LVL_W'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

@@ rtl/core/sobel_edge_magnitude.sv @@
// Streaming 3x3 Sobel edge detector. Pixels of a grayscale frame enter in raster
// order on the pixels channel, one per clock at full rate while the result queue has
// room; for each pixel the block returns |Gx|+|Gy| saturated at 255 on the edges
// channel, zero on the frame border, with last_of_frame marking the frame's final
// pixel. A result belongs to the pixel frame_width items earlier, so the last row of
// a frame only comes out when more pixels or flush items (kind = 1) follow; a flush
// with nothing pending is taken and dropped. The two previous rows live in one line
// memory of MAX_WIDTH words (older and newer row side by side) that is read at
// acceptance and written back in the next cycle, with a forward path when the next
// item hits the same column. Released results pass the stage 1 and stage 2 registers
// into a four-entry result queue that lets the input flow on while the output stalls.
// Set frame_width and frame_height only while no item is in flight; a width of 0
// acts as 1 and values above the maxima act as the maxima. There is no clearing pass:
// the line memory needs none while the width is not raised in mid-frame.
module sobel_edge_magnitude import sem_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	sem_stream_if.sink             pixels,
	sem_stream_if.source           edges
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int CB  = $clog2(MAX_WIDTH);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int RB  = $clog2(MAX_HEIGHT);
	localparam int BW  = $clog2(MAX_WIDTH + 2);
	localparam int CWW = (WW > FRAME_WIDTH_W) ? WW : FRAME_WIDTH_W;
	localparam int CHW = (HW > FRAME_HEIGHT_W) ? HW : FRAME_HEIGHT_W;
	localparam int WIDTH_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
	localparam int HEIGHT_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;
	localparam int LW = 2 * PIXEL_W;

	// Clamped frame bounds
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CWW-1:0] cfg_w_wide;
	logic [CHW-1:0] cfg_h_wide;

	// Raster positions and count of pixels not yet answered
	logic [CB-1:0] in_col_q, out_col_q;
	logic [RB-1:0] in_row_q, out_row_q;
	logic [BW-1:0] backlog_q;

	// Step logic
	logic              take, is_pix, feed, emit, emit_pix;
	logic [WW-1:0]     w_m1;
	logic [HW-1:0]     h_m1;
	logic [CB-1:0]     col_last;
	logic [RB-1:0]     row_last;
	logic [CB-1:0]     in_col_c, out_col_c, in_col_n, out_col_n, flush_col, addr;
	logic [RB-1:0]     in_row_c, out_row_c, in_row_n, out_row_n;
	logic [BW-1:0]     bl_inc, backlog_n;
	logic [PIXEL_W-1:0] feed_val;
	logic              border, last;

	// Line memory: {older row, newer row} per column
	logic [LW-1:0]     line_mem [MAX_WIDTH];
	logic [LW-1:0]     line_rd_s1;
	logic [LW-1:0]     fwd_s1;
	logic [LW-1:0]     line_word, wr_word;
	logic              hit_s1;
	logic              s1_valid;
	logic              emit_s1, border_s1, last_s1;
	logic [CB-1:0]     addr_s1;
	logic [PIXEL_W-1:0] val_s1;

	// Window and result stage
	logic [PIXEL_W-1:0] taps_q [3][3];
	logic              emit_s2, border_s2, last_s2;
	logic [PIXEL_W+1:0] pos_x, neg_x, pos_y, neg_y, abs_x, abs_y;
	logic [PIXEL_W+2:0] mag_sum;
	res_item_t         res;
	fifo_stat_t        fifo_stat;
	logic [FIFO_LVL_W-1:0] pending;

	// Configuration: store the bounds already clamped to their legal range
	assign cfg_w_wide = CWW'(cfg_data[FRAME_WIDTH_W-1:0]);
	assign cfg_h_wide = CHW'(cfg_data[FRAME_HEIGHT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(WIDTH_RST);
			height_q <= HW'(HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					if (cfg_w_wide == '0) begin
						width_q <= WW'(1);
					end else if (cfg_w_wide > CWW'(MAX_WIDTH)) begin
						width_q <= WW'(MAX_WIDTH);
					end else begin
						width_q <= cfg_w_wide[WW-1:0];
					end
				end
				CFG_FRAME_HEIGHT: begin
					if (cfg_h_wide == '0) begin
						height_q <= HW'(1);
					end else if (cfg_h_wide > CHW'(MAX_HEIGHT)) begin
						height_q <= HW'(MAX_HEIGHT);
					end else begin
						height_q <= cfg_h_wide[HW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Input side: room is counted against results still in flight
	assign pending = fifo_stat.level + FIFO_LVL_W'(emit_s1) + FIFO_LVL_W'(emit_s2);
	assign pixels.ready = pending < FIFO_LVL_W'(FIFO_DEPTH);
	assign take   = pixels.valid && pixels.ready;
	assign is_pix = pixels.data.kind == KIND_PIXEL;

	always_comb begin
		w_m1     = width_q - 1'b1;
		h_m1     = height_q - 1'b1;
		col_last = w_m1[CB-1:0];
		row_last = h_m1[RB-1:0];

		// Drop positions that a shrunken bound left out of range
		in_col_c  = (WW'(in_col_q) >= width_q) ? '0 : in_col_q;
		out_col_c = (WW'(out_col_q) >= width_q) ? '0 : out_col_q;
		in_row_c  = (HW'(in_row_q) >= height_q) ? '0 : in_row_q;
		out_row_c = (HW'(out_row_q) >= height_q) ? '0 : out_row_q;

		in_col_n = (in_col_c == col_last) ? '0 : in_col_c + 1'b1;
		in_row_n = in_row_c;
		if (in_col_c == col_last) begin
			in_row_n = (in_row_c == row_last) ? '0 : in_row_c + 1'b1;
		end
		out_col_n = (out_col_c == col_last) ? '0 : out_col_c + 1'b1;
		out_row_n = out_row_c;
		if (out_col_c == col_last) begin
			out_row_n = (out_row_c == row_last) ? '0 : out_row_c + 1'b1;
		end

		// A flush feeds the column just past the next result
		flush_col = out_col_n;

		bl_inc   = (backlog_q == BW'(MAX_WIDTH + 1)) ? backlog_q : backlog_q + 1'b1;
		emit_pix = bl_inc > BW'(width_q);

		feed     = take && (is_pix || backlog_q != '0);
		emit     = take && (is_pix ? emit_pix : backlog_q != '0);
		addr     = is_pix ? in_col_c : flush_col;
		feed_val = is_pix ? pixels.data.pixel : '0;

		if (is_pix) begin
			backlog_n = emit_pix ? bl_inc - 1'b1 : bl_inc;
		end else begin
			backlog_n = (backlog_q != '0) ? backlog_q - 1'b1 : backlog_q;
		end

		border = (out_row_c == '0) || (out_row_c == row_last) ||
			(out_col_c == '0) || (out_col_c == col_last);
		last   = (out_row_c == row_last) && (out_col_c == col_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			backlog_q <= '0;
		end else if (take) begin
			in_col_q  <= is_pix ? in_col_n : in_col_c;
			in_row_q  <= is_pix ? in_row_n : in_row_c;
			out_col_q <= emit ? out_col_n : out_col_c;
			out_row_q <= emit ? out_row_n : out_row_c;
			backlog_q <= backlog_n;
		end
	end

	// Stage 1: read data back, shift the column up, write it back
	assign line_word = hit_s1 ? fwd_s1 : line_rd_s1;
	assign wr_word   = {line_word[PIXEL_W-1:0], val_s1};

	always_ff @(posedge clk) begin
		if (feed) begin
			line_rd_s1 <= line_mem[addr];
		end
		if (s1_valid) begin
			line_mem[addr_s1] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		// Forward the word being written when the next item reads that column
		hit_s1    <= s1_valid && (addr == addr_s1);
		fwd_s1    <= wr_word;
		addr_s1   <= addr;
		val_s1    <= feed_val;
		border_s1 <= border;
		last_s1   <= last;
		border_s2 <= border_s1;
		last_s2   <= last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			emit_s1  <= 1'b0;
			emit_s2  <= 1'b0;
		end else begin
			s1_valid <= feed;
			emit_s1  <= emit;
			emit_s2  <= emit_s1;
		end
	end

	// Window: shift left, new right column from the line word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					taps_q[r][c] <= '0;
				end
			end
		end else if (s1_valid) begin
			for (int r = 0; r < 3; r++) begin
				taps_q[r][0] <= taps_q[r][1];
				taps_q[r][1] <= taps_q[r][2];
			end
			taps_q[0][2] <= line_word[LW-1:PIXEL_W];
			taps_q[1][2] <= line_word[PIXEL_W-1:0];
			taps_q[2][2] <= val_s1;
		end
	end

	// Stage 2: Sobel magnitude on the window, saturated
	always_comb begin
		pos_x = 10'(taps_q[0][2]) + {1'b0, taps_q[1][2], 1'b0} + 10'(taps_q[2][2]);
		neg_x = 10'(taps_q[0][0]) + {1'b0, taps_q[1][0], 1'b0} + 10'(taps_q[2][0]);
		pos_y = 10'(taps_q[0][0]) + {1'b0, taps_q[0][1], 1'b0} + 10'(taps_q[0][2]);
		neg_y = 10'(taps_q[2][0]) + {1'b0, taps_q[2][1], 1'b0} + 10'(taps_q[2][2]);
		abs_x = (pos_x > neg_x) ? pos_x - neg_x : neg_x - pos_x;
		abs_y = (pos_y > neg_y) ? pos_y - neg_y : neg_y - pos_y;
		mag_sum = 11'(abs_x) + 11'(abs_y);
		if (border_s2) begin
			res.edge_res = '0;
		end else if (mag_sum > 11'(255)) begin
			res.edge_res = 8'hFF;
		end else begin
			res.edge_res = mag_sum[PIXEL_W-1:0];
		end
		res.last_of_frame = last_s2;
	end

	sem_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s2),
		.push_data (res),
		.stat      (fifo_stat),
		.edges     (edges)
	);

	// The queue never takes a result while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_s2 && fifo_stat.full))
		else $error("result queue overflow");

	// A forward hit only follows a write-back in the cycle before
	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && hit_s1 |-> $past(s1_valid))
		else $error("forward without write-back");

	// The frame's last pixel lies on the border
	a_last_border: assert property (@(posedge clk) disable iff (!arst_n)
		edges.valid && edges.data.last_of_frame |-> edges.data.edge_res == '0)
		else $error("nonzero result on last pixel");

	// A released result always reaches the queue through emit_s1 and emit_s2
	a_emit_path: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ##2 emit_s2)
		else $error("result lost in pipeline");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import sem_pkg::*;

	// Bounds the block is built with; the edge predictor clamps to the same values
	localparam int unsigned LINE_MAX = 1024;
	localparam int unsigned ROWS_MAX = 4096;

	localparam realtime     CLK_PERIOD      = 12.0;
	localparam int unsigned SETTLE_CYCLES   = 16;      // result latency plus queue depth, padded
	localparam int unsigned STALL_CYCLES    = 300;     // long receiver hold-off
	localparam int unsigned WATCHDOG_CYCLES = 500000;
	localparam int unsigned REPORT_CAP      = 40;
	localparam int unsigned PREFILL_WIDTH   = 64;      // above the widest random frame

	typedef enum int {TEXTURE_NOISE, TEXTURE_STARK, TEXTURE_BLOCKS} texture_t;

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	sem_stream_if #(.T(pix_item_t)) pixels_if ();
	sem_stream_if #(.T(res_item_t)) edges_if ();

	sobel_edge_magnitude #(
		.MAX_WIDTH (LINE_MAX),
		.MAX_HEIGHT(ROWS_MAX)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pixels_if),
		.edges    (edges_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Idle percentages of the two sides; the test tasks switch them per phase
	int unsigned send_idle_pct = 16;
	int unsigned recv_idle_pct = 48;
	// Remaining cycles of a forced receiver hold-off; set at a rising edge only
	int unsigned hold_left = 0;

	// ------------------------------------------------------------------
	// Edge predictor: its own copy of the bounds, line stores, window and
	// raster counters. Updated once per accepted item.
	// ------------------------------------------------------------------
	logic [FRAME_WIDTH_W-1:0]  cfg_width  = FRAME_WIDTH_W'(FRAME_WIDTH_RST);
	logic [FRAME_HEIGHT_W-1:0] cfg_height = FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
	logic [PIXEL_W-1:0]        older_line [LINE_MAX];
	logic [PIXEL_W-1:0]        newer_line [LINE_MAX];
	logic [PIXEL_W-1:0]        win [3][3];
	int unsigned               in_col  = 0;
	int unsigned               in_row  = 0;
	int unsigned               out_col = 0;
	int unsigned               out_row = 0;
	int unsigned               backlog_cnt = 0;     // pixels taken but not yet answered

	res_item_t   expected_edges [$];

	// Run statistics
	int unsigned mismatch_count = 0;
	int unsigned edge_results   = 0;
	int unsigned pixel_items    = 0;
	int unsigned flush_items    = 0;
	int unsigned live_items     = 0;    // items that changed the block's state
	int unsigned bound_settings = 0;

	initial begin
		for (int i = 0; i < LINE_MAX; i++) begin
			older_line[i] = '0;
			newer_line[i] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				win[r][c] = '0;
			end
		end
	end

	// Zero acts as one, anything above the build limit as the limit
	function automatic int unsigned clamp_bound(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Shift one value through the line stores at a column and into the window
	function automatic void shift_in(int unsigned col, logic [PIXEL_W-1:0] v);
		logic [PIXEL_W-1:0] top;
		logic [PIXEL_W-1:0] mid;
		int                 r;
		top = older_line[col];
		mid = newer_line[col];
		older_line[col] = mid;
		newer_line[col] = v;
		for (r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = v;
	endfunction

	// Queue the result for the current output position and advance that position
	function automatic void emit_edge(int unsigned w, int unsigned h);
		int        gx;
		int        gy;
		int        mag;
		res_item_t want;
		if (out_row == 0 || out_row == h - 1 || out_col == 0 || out_col == w - 1) begin
			mag = 0;
		end else begin
			gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
			   - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
			gy = (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]))
			   - (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]));
			if (gx < 0) gx = -gx;
			if (gy < 0) gy = -gy;
			mag = gx + gy;
			if (mag > 255) mag = 255;
		end
		want.edge_res      = PIXEL_W'(mag);
		want.last_of_frame = (out_row == h - 1 && out_col == w - 1);
		expected_edges.push_back(want);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) out_row = 0;
		end
		backlog_cnt--;
	endfunction

	function automatic void sobel_predict(logic item_kind, logic [PIXEL_W-1:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		w = clamp_bound(cfg_width, LINE_MAX);
		h = clamp_bound(cfg_height, ROWS_MAX);
		// Bounds may have shrunk since the last item: restart counters past them
		if (in_col >= w) in_col = 0;
		if (in_row >= h) in_row = 0;
		if (out_col >= w) out_col = 0;
		if (out_row >= h) out_row = 0;
		if (item_kind == KIND_PIXEL) begin
			pixel_items++;
			live_items++;
			shift_in(in_col, px);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) in_row = 0;
			end
			if (backlog_cnt < LINE_MAX + 1) backlog_cnt++;
			if (backlog_cnt > w) emit_edge(w, h);
		end else if (backlog_cnt != 0) begin
			// A flush feeds a zero one column ahead of the output position
			flush_items++;
			live_items++;
			col = (out_col + 1 >= w) ? 0 : out_col + 1;
			shift_in(col, '0);
			emit_edge(w, h);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checker: compare every accepted result with the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what);
		if (mismatch_count < REPORT_CAP) $display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_edges
		res_item_t got;
		res_item_t want;
		if (arst_n && edges_if.valid && edges_if.ready) begin
			got = edges_if.data;
			if (expected_edges.size() == 0) begin
				report_mismatch($sformatf("result edge=%0d last=%0b with none expected",
					got.edge_res, got.last_of_frame));
			end else begin
				want = expected_edges.pop_front();
				edge_results++;
				if (got.edge_res !== want.edge_res)
					report_mismatch($sformatf("result %0d: edge_res %0d, want %0d",
						edge_results, got.edge_res, want.edge_res));
				if (got.last_of_frame !== want.last_of_frame)
					report_mismatch($sformatf("result %0d: last_of_frame %0b, want %0b",
						edge_results, got.last_of_frame, want.last_of_frame));
			end
		end
	end

	// Receiver: honor a forced hold-off first, otherwise stall at random
	always @(negedge clk) begin
		if (hold_left != 0) begin
			edges_if.ready <= 1'b0;
			hold_left--;
		end else begin
			edges_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. Every task starts and ends at a falling edge.
	// ------------------------------------------------------------------

	// Offer one item, wait for its handshake, predict. Valid stays high on
	// return so that back-to-back items need no extra cycle.
	task automatic push_item(logic item_kind, logic [PIXEL_W-1:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			pixels_if.valid <= 1'b0;
			@(negedge clk);
		end
		pixels_if.valid <= 1'b1;
		pixels_if.data  <= '{kind: item_kind, pixel: px};
		do @(posedge clk); while (!pixels_if.ready);
		sobel_predict(item_kind, px);
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected result, then let the pipe settle
	task automatic quiesce();
		pixels_if.valid <= 1'b0;
		do @(negedge clk); while (expected_edges.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAME_WIDTH:  cfg_width  = val[FRAME_WIDTH_W-1:0];
			CFG_FRAME_HEIGHT: cfg_height = val[FRAME_HEIGHT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_bounds(int unsigned w, int unsigned h);
		write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
		bound_settings++;
	endtask

	function automatic logic [PIXEL_W-1:0] pick_pixel(texture_t tex);
		case (tex)
			TEXTURE_NOISE: return PIXEL_W'($urandom_range(255));
			TEXTURE_STARK: return $urandom_range(1) ? 8'hFF : 8'h00;
			default:       return PIXEL_W'(($urandom_range(1) ? 200 : 40) + $urandom_range(7));
		endcase
	endfunction

	// Stream pixels; in noisy mode, scatter short flush bursts in mid-frame
	task automatic send_pixels(int unsigned count, texture_t tex, bit noisy);
		for (int unsigned i = 0; i < count; i++) begin
			if (noisy && $urandom_range(63) == 0)
				repeat ($urandom_range(1, 6)) push_item(KIND_FLUSH, PIXEL_W'($urandom));
			push_item(KIND_PIXEL, pick_pixel(tex));
		end
	endtask

	// Push out every pending result with flush items
	task automatic drain_backlog();
		while (backlog_cnt != 0) push_item(KIND_FLUSH, PIXEL_W'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Flush items with nothing pending are taken and dropped
	task automatic test_flush_when_empty();
		push_item(KIND_FLUSH, 8'hFF);
		push_item(KIND_FLUSH, 8'h00);
		push_item(KIND_FLUSH, 8'hA5);
		quiesce();
	endtask

	// Three-row frame wider than any later random frame, with real edges in
	// the middle row. It fills every line-store column the later frames can
	// reach, so none of them reads a column that was never filled.
	task automatic test_wide_line();
		set_bounds(PREFILL_WIDTH, 3);
		send_pixels(PREFILL_WIDTH * 3, TEXTURE_NOISE, 1'b0);
		drain_backlog();
		quiesce();
	endtask

	// Bounds beyond the maxima act as the maxima; flush a short row start
	// out in mid-frame
	task automatic test_oversize_bounds();
		set_bounds((1 << FRAME_WIDTH_W) - 1, (1 << FRAME_HEIGHT_W) - 1);
		push_item(KIND_PIXEL, 8'h00);
		push_item(KIND_PIXEL, 8'hFF);
		push_item(KIND_PIXEL, 8'h55);
		push_item(KIND_PIXEL, 8'hAA);
		drain_backlog();
		quiesce();
	endtask

	// Shrink the bounds below the current column (counters restart), then a
	// 3x3 frame with a hard vertical step: the center saturates at 255
	task automatic test_saturation();
		logic [PIXEL_W-1:0] step_frame [9] = '{8'h00, 8'h00, 8'hFF,
		                                        8'h00, 8'h00, 8'hFF,
		                                        8'h00, 8'h00, 8'hFF};
		set_bounds(3, 3);
		foreach (step_frame[i]) push_item(KIND_PIXEL, step_frame[i]);
		drain_backlog();
		quiesce();
	endtask

	// Zero bounds act as one: every pixel is a whole frame on its own border
	task automatic test_unit_bounds();
		set_bounds(0, 0);
		push_item(KIND_PIXEL, 8'hFF);
		push_item(KIND_PIXEL, 8'h7F);
		drain_backlog();
		quiesce();
	endtask

	// Random phases: mostly complete frames with random content, some cut
	// short, some with flush bursts in mid-frame and spare flushes at the end
	task automatic test_random_frames(int unsigned tx_idle, int unsigned rx_idle,
	                                  int unsigned target);
		int unsigned goal;
		int unsigned w;
		int unsigned h;
		int unsigned npix;
		texture_t    tex;
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		goal = live_items + target;
		while (live_items < goal) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
			h = $urandom_range(1, 10);
			if ($urandom_range(15) == 0) w = 0;
			if ($urandom_range(15) == 0) h = 0;
			set_bounds(w, h);
			tex  = texture_t'($urandom_range(2));
			npix = $urandom_range(1, 2) * clamp_bound(w, LINE_MAX) * clamp_bound(h, ROWS_MAX);
			// Broken sequence: stop somewhere inside the frame
			if ($urandom_range(5) == 0) npix = $urandom_range(npix);
			send_pixels(npix, tex, 1'b1);
			drain_backlog();
			if ($urandom_range(3) == 0) push_item(KIND_FLUSH, PIXEL_W'($urandom));
			quiesce();
		end
	endtask

	// Hold the receiver off for a long stretch while the sender keeps
	// offering a frame: the result queue fills and the input must stall
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_bounds(5, 6);
		@(posedge clk);
		hold_left = STALL_CYCLES;
		@(negedge clk);
		send_pixels(30, TEXTURE_BLOCKS, 1'b0);
		drain_backlog();
		quiesce();
	endtask

	initial begin
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		pixels_if.valid = 1'b0;
		pixels_if.data  = '0;
		edges_if.ready  = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, sender idling lightly, receiver heavily
		test_flush_when_empty();
		test_wide_line();
		test_oversize_bounds();
		test_saturation();
		test_unit_bounds();

		// Random part: swap the idle pattern, squeeze the output, then full rate
		test_random_frames(16, 48, 460);
		test_random_frames(48, 16, 460);
		test_output_stall();
		test_random_frames(0, 0, 450);

		quiesce();
		$display("Covered %0d pixel and %0d flush items over %0d frame bound settings,",
			pixel_items, flush_items, bound_settings);
		$display("including clamped oversize and degenerate bounds; %0d results checked, %0d bad.",
			edge_results, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: a hang anywhere ends the run as a failure
	initial begin
		#(CLK_PERIOD * WATCHDOG_CYCLES);
		$display("Timeout with %0d results still expected.", expected_edges.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
